>>> sv/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants for the contact debounce and timeout block.
// ----------------------------------------------------------------------------
package cdt_pkg;

  // field widths
  localparam int unsigned LEG_W       = 2;
  localparam int unsigned RUN_W       = 4;
  localparam int unsigned DEBOUNCE_W  = 4;
  localparam int unsigned TIMEOUT_W   = 10;
  localparam int unsigned VEC_W       = 4;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // number of legs a message can name
  localparam int unsigned LEG_SPAN = 1 << LEG_W;

  // run counter saturation value
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(3);
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = TIMEOUT_W'(150);

  // register index, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  // item kind carried on tuser
  typedef enum logic {
    FUNC_MSG  = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  // configuration registers
  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_count;
    logic [TIMEOUT_W-1:0]  timeout_ticks;
  } cfg_t;

  // per-leg update strobe, already qualified by the pipeline advance
  typedef struct packed {
    logic msg;
    logic tick;
    logic reading;
  } leg_cmd_t;

endpackage

>>> sv/cdt_cfg.sv
// ----------------------------------------------------------------------------
// cdt_cfg
// APB register file holding the debounce count and the timeout in ticks.
// ----------------------------------------------------------------------------
module cdt_cfg import cdt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_DEBOUNCE: cfg_d.debounce_count = pwdata[DEBOUNCE_W-1:0];
        REG_TIMEOUT:  cfg_d.timeout_ticks  = pwdata[TIMEOUT_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_count <= DEBOUNCE_RST;
      cfg_q.timeout_ticks  <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE: prdata = APB_DATA_W'(cfg_q.debounce_count);
      REG_TIMEOUT:  prdata = APB_DATA_W'(cfg_q.timeout_ticks);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/cdt_leg.sv
// ----------------------------------------------------------------------------
// cdt_leg
// One leg: counter debounce of the contact reading and a saturating age
// counter. Gives the next accepted state and the next report bit.
// ----------------------------------------------------------------------------
module cdt_leg import cdt_pkg::*; #(
  parameter int unsigned AGE_WIDTH = 11
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  leg_cmd_t cmd_i,
  input  cfg_t     cfg_i,
  output logic     accepted_d_o,
  output logic     report_d_o
);

  localparam int unsigned CMP_W = (AGE_WIDTH > TIMEOUT_W) ? AGE_WIDTH : TIMEOUT_W;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

  logic                 accepted_q, accepted_d;
  logic                 pending_q, pending_d;
  logic [RUN_W-1:0]     run_q, run_d;
  logic [AGE_WIDTH-1:0] age_q, age_d;
  logic [RUN_W-1:0]     run_inc;

  // debounce and age update
  always_comb begin
    accepted_d = accepted_q;
    pending_d  = pending_q;
    run_d      = run_q;
    age_d      = age_q;
    run_inc    = RUN_W'(1);
    if (cmd_i.msg) begin
      age_d     = '0;
      pending_d = cmd_i.reading;
      if (cmd_i.reading == accepted_q) begin
        run_d = '0;
      end else begin
        // extend a run of the same opposite value, else start a new one
        if (cmd_i.reading == pending_q) begin
          run_inc = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);
        end
        if (run_inc >= cfg_i.debounce_count) begin
          accepted_d = cmd_i.reading;
          run_d      = '0;
        end else begin
          run_d = run_inc;
        end
      end
    end else if (cmd_i.tick) begin
      if (age_q != AGE_MAX) begin
        age_d = age_q + AGE_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_q <= 1'b0;
      pending_q  <= 1'b0;
      run_q      <= '0;
      age_q      <= '0;
    end else begin
      accepted_q <= accepted_d;
      pending_q  <= pending_d;
      run_q      <= run_d;
      age_q      <= age_d;
    end
  end

  // stale legs report no contact
  assign accepted_d_o = accepted_d;
  assign report_d_o   = accepted_d & (CMP_W'(age_d) <= CMP_W'(cfg_i.timeout_ticks));

endmodule

>>> sv/contact_debounce_timeout.sv
// ----------------------------------------------------------------------------
// contact_debounce_timeout
// Per-leg contact qualifier: counter debounce of contact messages plus a
// staleness timeout driven by tick items.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                | payload
//  s_axis    | in  | tvalid / tready          | tuser: func; tdata: leg, reading
//  m_axis    | out | tvalid / tready          | tdata: reported, debounced
//  apb       | in  | psel, penable, pready=1  | debounce_count @0, timeout_ticks @4
//
//  one word accepted per cycle while m_axis takes results; its result word passes through
//  the input register, then the result register after the leg update logic
//  leg state updates at the edge the word moves into the result register
//  a stalled m_axis holds the result; one more word can wait in the input
//  register, then s_axis_tready stays low until m_axis takes the result
//  reset clears all leg state and restores debounce 3, timeout 150
// ----------------------------------------------------------------------------
module contact_debounce_timeout import cdt_pkg::*; #(
  parameter int unsigned LEGS      = 4,
  parameter int unsigned AGE_WIDTH = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [1:0] leg, [2] reading, [7:3] zero
  input  logic                   s_axis_tuser,   // [0] func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] reported, [7:4] debounced
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  cfg_t             cfg;
  logic             in_valid_q, in_valid_d;
  func_e            in_func_q;
  logic [LEG_W-1:0] in_leg_q;
  logic             in_reading_q;
  logic             in_take;
  logic             advance;
  logic             out_valid_q, out_valid_d;
  logic [VEC_W-1:0] reported_q, debounced_q;
  logic [VEC_W-1:0] reported_d, debounced_d;
  logic [LEGS-1:0]  leg_acc_d, leg_rep_d;

  // configuration registers
  cdt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline flow control
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign in_valid_d    = in_take | (in_valid_q & ~advance);
  assign out_valid_d   = advance | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q    <= func_e'(s_axis_tuser);
      in_leg_q     <= s_axis_tdata[LEG_W-1:0];
      in_reading_q <= s_axis_tdata[LEG_W];
    end
  end

  // leg units
  for (genvar i = 0; i < LEGS; i++) begin : g_leg
    leg_cmd_t cmd;
    if (i < LEG_SPAN) begin : g_addr
      assign cmd.msg = advance & (in_func_q == FUNC_MSG) & (in_leg_q == LEG_W'(i));
    end else begin : g_noaddr
      assign cmd.msg = 1'b0;
    end
    assign cmd.tick    = advance & (in_func_q == FUNC_TICK);
    assign cmd.reading = in_reading_q;

    cdt_leg #(
      .AGE_WIDTH (AGE_WIDTH)
    ) u_leg (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .cfg_i        (cfg),
      .accepted_d_o (leg_acc_d[i]),
      .report_d_o   (leg_rep_d[i])
    );
  end

  // gather the visible legs into the result vectors
  for (genvar j = 0; j < VEC_W; j++) begin : g_vec
    if (j < LEGS) begin : g_on
      assign debounced_d[j] = leg_acc_d[j];
      assign reported_d[j]  = leg_rep_d[j];
    end else begin : g_off
      assign debounced_d[j] = 1'b0;
      assign reported_d[j]  = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      reported_q  <= reported_d;
      debounced_q <= debounced_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {debounced_q, reported_q};

endmodule

>>> sv/cdt_checker.sv
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks for contact_debounce_timeout, attached by bind.
// ----------------------------------------------------------------------------
module cdt_checker import cdt_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   pready
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // a leg can only report contact when its debounced state is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[VEC_W-1:0] & ~m_axis_tdata[2*VEC_W-1:VEC_W]) == '0)
    else $error("reported bit set without debounced bit");

  // with the result register empty the input side is always open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // result register comes out of reset empty
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid as reset releases");

  // config port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind contact_debounce_timeout cdt_checker u_cdt_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contact debounce and timeout block. A table
// of directed words and register writes comes first, then a phase that
// lets every leg age out. Random phases follow, over several debounce and
// timeout settings. Each result word is compared against a local predictor
// of the leg state.
// ----------------------------------------------------------------------------
module tb;
  import cdt_pkg::*;

  localparam int unsigned LEGS        = 4;
  localparam int unsigned AGE_W       = 11;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 23;
  localparam int unsigned SAT_TICKS   = 60;

  // result word as it sits on m_axis_tdata, low field last
  typedef struct packed {
    logic [VEC_W-1:0] debounced;
    logic [VEC_W-1:0] reported;
  } contact_vec_t;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_REG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    func_e            func;
    logic [LEG_W-1:0] leg;
    logic             reading;
    logic             reg_sel;
    logic [31:0]      value;
    logic             typed;
    contact_vec_t     vec;
  } stim_row_t;

  // directed table: typed results only where obvious
  stim_row_t dir_rows [29] = '{
    '{ROW_WORD, FUNC_TICK, 2'd0, 1'b0, REG_DEBOUNCE, 32'd0,    1'b1, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd0, 1'b0, REG_DEBOUNCE, 32'd0,    1'b1, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd3, 1'b1, REG_DEBOUNCE, 32'd0,    1'b1, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd3, 1'b1, REG_DEBOUNCE, 32'd0,    1'b1, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd3, 1'b1, REG_DEBOUNCE, 32'd0,    1'b1, 8'h88},
    '{ROW_WORD, FUNC_MSG,  2'd0, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd0, 1'b0, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd0, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd0, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd0, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd1, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd2, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd1, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd2, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd1, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd2, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd3, 1'b0, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd3, 1'b0, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd3, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_TICK, 2'd0, 1'b0, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_REG,  FUNC_MSG,  2'd0, 1'b0, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_REG,  FUNC_MSG,  2'd0, 1'b0, REG_TIMEOUT,  32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd2, 1'b0, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_TICK, 2'd0, 1'b0, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd1, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_WORD, FUNC_MSG,  2'd3, 1'b0, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00},
    '{ROW_REG,  FUNC_MSG,  2'd0, 1'b0, REG_DEBOUNCE, 32'd15,   1'b0, 8'h00},
    '{ROW_REG,  FUNC_MSG,  2'd0, 1'b0, REG_TIMEOUT,  32'd1023, 1'b0, 8'h00},
    '{ROW_WORD, FUNC_TICK, 2'd3, 1'b1, REG_DEBOUNCE, 32'd0,    1'b0, 8'h00}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [1:0] leg, [2] reading, [7:3] zero
  logic                   s_axis_tuser  = 1'b0; // [0] func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [3:0] reported, [7:4] debounced
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr         = '0;
  logic [APB_DATA_W-1:0]  pwdata        = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // predicted leg state and registers
  logic [VEC_W-1:0]      acc_state;
  logic [VEC_W-1:0]      pend_val;
  logic [RUN_W-1:0]      pend_run [LEGS];
  logic [AGE_W-1:0]      leg_age  [LEGS];
  logic [DEBOUNCE_W-1:0] deb_cnt;
  logic [TIMEOUT_W-1:0]  tmo_ticks;

  contact_vec_t contact_vec_q [$];
  int unsigned  errors    = 0;
  int unsigned  cycle_cnt = 0;
  logic         calm      = 1'b0;

  contact_debounce_timeout #(
    .LEGS      (LEGS),
    .AGE_WIDTH (AGE_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // leg update for one word, returns the vectors seen after it
  function automatic contact_vec_t qualify_contacts(func_e f, logic [LEG_W-1:0] leg,
                                                    logic rd);
    contact_vec_t v;
    if (f == FUNC_MSG) begin
      leg_age[leg] = '0;
      if (rd == acc_state[leg]) begin
        pend_run[leg] = '0;
        pend_val[leg] = rd;
      end else begin
        if (rd == pend_val[leg]) begin
          if (pend_run[leg] != RUN_MAX) pend_run[leg]++;
        end else begin
          pend_val[leg] = rd;
          pend_run[leg] = RUN_W'(1);
        end
        if (pend_run[leg] >= deb_cnt) begin
          acc_state[leg] = rd;
          pend_run[leg]  = '0;
        end
      end
    end else begin
      // ages saturate at all ones
      for (int i = 0; i < LEGS; i++) begin
        if (leg_age[i] != '1) leg_age[i]++;
      end
    end
    v.debounced = acc_state;
    for (int i = 0; i < LEGS; i++) begin
      v.reported[i] = acc_state[i] && (leg_age[i] <= AGE_W'(tmo_ticks));
    end
    return v;
  endfunction

  // present one input word, predict it once accepted
  task automatic send_word(func_e f, logic [LEG_W-1:0] leg, logic rd, logic typed,
                           contact_vec_t typed_vec);
    contact_vec_t v;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {{(IN_TDATA_W-LEG_W-1){1'b0}}, rd, leg};
    do @(posedge clk_i); while (!s_axis_tready);
    v = qualify_contacts(f, leg, rd);
    if (typed) v = typed_vec;
    contact_vec_q.push_back(v);
  endtask

  // stop sending and wait for every expected word
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (contact_vec_q.size() != 0) @(posedge clk_i);
  endtask

  // one apb transfer, psel left high for a following transfer
  task automatic apb_xfer(logic wr, logic [APB_ADDR_W-1:0] addr, logic [31:0] data,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  // register write while idle, then read back
  task automatic write_reg(logic sel, logic [31:0] value);
    logic [APB_ADDR_W-1:0] addr;
    logic [31:0]           rdata;
    logic [31:0]           want;
    addr = {sel, 2'b00};
    drain();
    apb_xfer(1'b1, addr, value, rdata);
    if (sel == REG_DEBOUNCE) begin
      deb_cnt = value[DEBOUNCE_W-1:0];
      want    = 32'(deb_cnt);
    end else begin
      tmo_ticks = value[TIMEOUT_W-1:0];
      want      = 32'(tmo_ticks);
    end
    apb_xfer(1'b0, addr, '0, rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata != want) begin
      $error("prdata: expected %0h, actual %0h", want, rdata);
      errors++;
    end
    @(posedge clk_i);
  endtask

  // random mix: mostly runs of steady readings per leg, some noise and ticks
  task automatic run_phase(logic [31:0] deb, logic [31:0] tmo, int n, int tick_pct,
                           int flip_pct, int noise_pct);
    logic [LEGS-1:0]  target;
    func_e            f;
    logic [LEG_W-1:0] leg;
    logic             rd;
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_TIMEOUT, tmo);
    target = LEGS'($urandom());
    repeat (n) begin
      leg = LEG_W'($urandom_range(LEGS-1));
      rd  = 1'($urandom_range(1));
      if ($urandom_range(99) < tick_pct) begin
        f = FUNC_TICK;
      end else begin
        f = FUNC_MSG;
        if ($urandom_range(99) < flip_pct) target[leg] = ~target[leg];
        if ($urandom_range(99) >= noise_pct) rd = target[leg];
      end
      send_word(f, leg, rd, 1'b0, '0);
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    contact_vec_t got;
    contact_vec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (contact_vec_q.size() == 0) begin
        $error("result word %0h with no expectation", m_axis_tdata);
        errors++;
      end else begin
        want = contact_vec_q.pop_front();
        if (got.reported != want.reported) begin
          $error("reported: expected %0h, actual %0h", want.reported, got.reported);
          errors++;
        end
        if (got.debounced != want.debounced) begin
          $error("debounced: expected %0h, actual %0h", want.debounced, got.debounced);
          errors++;
        end
      end
    end
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // main sequence
  initial begin
    acc_state = '0;
    pend_val  = '0;
    for (int i = 0; i < LEGS; i++) begin
      pend_run[i] = '0;
      leg_age[i]  = '0;
    end
    deb_cnt   = DEBOUNCE_RST;
    tmo_ticks = TIMEOUT_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
      end else begin
        send_word(dir_rows[i].func, dir_rows[i].leg, dir_rows[i].reading,
                  dir_rows[i].typed, dir_rows[i].vec);
      end
    end

    // every leg on, then age past the timeout
    write_reg(REG_DEBOUNCE, 32'd1);
    write_reg(REG_TIMEOUT, 32'd50);
    for (int i = 0; i < LEGS; i++) send_word(FUNC_MSG, LEG_W'(i), 1'b1, 1'b0, '0);
    repeat (SAT_TICKS) begin
      send_word(FUNC_TICK, LEG_W'($urandom_range(LEGS-1)), 1'($urandom_range(1)), 1'b0, '0);
    end
    for (int i = 0; i < LEGS; i++) begin
      send_word(FUNC_MSG, LEG_W'(i), 1'($urandom_range(1)), 1'b0, '0);
    end

    // random phases over several settings
    run_phase(32'd1, 32'd4, 110, 35, 20, 10);
    calm = 1'b1;
    run_phase(32'd15, 32'd1023, 160, 10, 4, 2);
    calm = 1'b0;
    run_phase(32'd0, 32'd0, 100, 30, 25, 10);
    run_phase(32'd15, 32'd1, 120, 40, 5, 2);
    run_phase(32'd2, 32'd20, 110, 25, 20, 10);
    run_phase($urandom(), $urandom(), 110, 30, 15, 8);
    run_phase(32'd5, 32'd150, 100, 20, 12, 6);

    drain();
    repeat (8) @(posedge clk_i);
    if (contact_vec_q.size() != 0) begin
      $error("%0d expected words never arrived", contact_vec_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
